### rtl/bhw_pkg.sv
// Shared types, constants and character-class functions for the box header walker.
package bhw_pkg;

  localparam int POS_W = 48;
  localparam int LEN_W = 64;
  localparam int TYPE_W = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 48;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [4:0] HDR_PLAIN = 5'd8;
  localparam logic [4:0] HDR_EXT = 5'd16;

  localparam logic [3:0] IDX_LAST_PLAIN = 4'd7;
  localparam logic [3:0] IDX_EXT_FIRST = 4'd8;
  localparam logic [3:0] IDX_LAST_EXT = 4'd15;
  localparam logic [3:0] IDX_TYPE_FIRST = 4'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SCAN_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TYPE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_LENGTH = 8'd3;

  localparam logic [POS_W-1:0] REGION_LENGTH_RST = 48'd8;

  localparam logic [2:0] ST_BOX = 3'd0;
  localparam logic [2:0] ST_MATCH = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE = 3'd2;
  localparam logic [2:0] ST_REGION_END = 3'd3;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd4;

  localparam logic SCAN_LIST = 1'b0;
  localparam logic SCAN_FIND = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [63:0] box_offset;
    logic [4:0]  header_length;
    logic [63:0] box_length;
    logic [31:0] box_type;
    logic        type_ok;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic              scan_mode;
    logic [TYPE_W-1:0] target_type;
    logic [POS_W-1:0]  region_start;
    logic [POS_W-1:0]  region_length;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [3:0]        header_byte_count;
    logic [LEN_W-1:0]  length_acc;
    logic [TYPE_W-1:0] type_acc;
    logic [POS_W-1:0]  box_start;
    logic              extended_header;
    logic [LEN_W-1:0]  body_bytes_left;
    logic              walk_finished;
  } walk_state_t;

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic type_rule(input logic [TYPE_W-1:0] t);
    return is_letter(t[31:24]) && is_letter(t[23:16]) &&
           (is_letter(t[15:8]) || is_digit(t[15:8]) || is_white(t[15:8])) &&
           (is_letter(t[7:0]) || is_white(t[7:0]));
  endfunction

  function automatic logic [POS_W-1:0] pos_advance(input logic [POS_W-1:0] p);
    return (p == POS_MAX) ? p : p + 48'd1;
  endfunction

endpackage

### rtl/bhw_step.sv
// One-byte state update and result decode of the box header walker.
module bhw_step (
  input  bhw_pkg::walk_state_t cur,
  input  bhw_pkg::in_item_t    item,
  input  bhw_pkg::cfg_t        cfg,
  output bhw_pkg::walk_state_t nxt,
  output logic                 emit,
  output bhw_pkg::out_item_t   res
);
  import bhw_pkg::*;

  walk_state_t      s;
  logic             run_hdr;
  logic             hdr_done;
  logic [3:0]       idx;
  logic [4:0]       hl;
  logic             ok;
  logic [POS_W:0]   off;
  logic [POS_W:0]   used;
  logic [POS_W:0]   end_off;

  always_comb begin
    s = cur;
    emit = 1'b0;
    res = '0;
    run_hdr = 1'b0;
    hdr_done = 1'b0;
    hl = HDR_PLAIN;
    idx = '0;
    ok = 1'b0;
    off = '0;
    used = '0;
    end_off = '0;
    if (item.restart) begin
      s = '0;
    end
    if (!s.walk_finished) begin
      run_hdr = 1'b1;
      if (s.header_byte_count == '0) begin
        end_off = {1'b0, cfg.region_start} + {1'b0, s.position};
        if (s.body_bytes_left != '0) begin
          s.body_bytes_left = s.body_bytes_left - 64'd1;
          s.position = pos_advance(s.position);
          run_hdr = 1'b0;
        end else if (({1'b0, s.position} + 49'd8) > {1'b0, cfg.region_length}) begin
          // fewer than a plain header's bytes left in the region
          s.walk_finished = 1'b1;
          emit = 1'b1;
          res.box_offset = {15'd0, end_off};
          res.status = ST_REGION_END;
          run_hdr = 1'b0;
        end else begin
          s.box_start = s.position;
          s.length_acc = '0;
          s.type_acc = '0;
          s.extended_header = 1'b0;
        end
      end
      if (run_hdr) begin
        idx = s.header_byte_count;
        if (idx < IDX_TYPE_FIRST) begin
          s.length_acc = {s.length_acc[55:0], item.data_byte};
        end else if (idx <= IDX_LAST_PLAIN) begin
          s.type_acc = {s.type_acc[23:0], item.data_byte};
        end else begin
          s.length_acc = {(idx == IDX_EXT_FIRST) ? 56'd0 : s.length_acc[55:0],
                          item.data_byte};
        end
        s.position = pos_advance(s.position);
        s.header_byte_count = idx + 4'd1;
        off = {1'b0, cfg.region_start} + {1'b0, s.box_start};
        ok = type_rule(s.type_acc);
        res.box_offset = {15'd0, off};
        res.box_type = s.type_acc;
        res.box_length = s.length_acc;
        res.type_ok = ok;
        if (idx == IDX_LAST_PLAIN) begin
          if (cfg.scan_mode == SCAN_LIST && !ok) begin
            s.walk_finished = 1'b1;
            s.header_byte_count = '0;
            emit = 1'b1;
            res.header_length = HDR_PLAIN;
            res.status = ST_BAD_TYPE;
          end else if (s.length_acc == 64'd1) begin
            s.extended_header = 1'b1;
          end else begin
            hdr_done = 1'b1;
            hl = HDR_PLAIN;
          end
        end else if (idx == IDX_LAST_EXT) begin
          hdr_done = 1'b1;
          hl = HDR_EXT;
        end
        if (hdr_done) begin
          s.header_byte_count = '0;
          res.header_length = hl;
          used = {1'b0, s.box_start} + {44'd0, hl};
          if (cfg.scan_mode == SCAN_FIND && s.type_acc == cfg.target_type) begin
            s.walk_finished = 1'b1;
            emit = 1'b1;
            res.status = ST_MATCH;
          end else if (s.length_acc != '0 && s.length_acc < {59'd0, hl}) begin
            s.walk_finished = 1'b1;
            emit = 1'b1;
            res.status = ST_BAD_LENGTH;
          end else begin
            if (s.length_acc == '0) begin
              // box runs to region end
              s.body_bytes_left = ({1'b0, cfg.region_length} > used) ?
                                  {16'd0, cfg.region_length - used[POS_W-1:0]} : '0;
            end else begin
              s.body_bytes_left = s.length_acc - {59'd0, hl};
            end
            emit = (cfg.scan_mode == SCAN_LIST);
            res.status = ST_BOX;
          end
        end
      end
    end
    nxt = s;
  end

endmodule

### rtl/box_header_walker_core.sv
// Box header walker top level: config registers, input and result registers.
// Takes one stream byte per transaction and can accept a byte every cycle while
// the input is not stalled; a byte lands in the input register, its header/body
// bookkeeping is done in one pass of bhw_step, and any result is loaded into the
// result register, which drives the output. A stalled result holds the result
// register and, with a byte waiting in the input register, stalls the input. At
// most one result per byte. Configuration writes take effect at once and
// cfg_ready is always high; write them only while no bytes are in flight.
// Restart marks the region's first byte.
module box_header_walker_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bhw_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bhw_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bhw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bhw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bhw_pkg::*;

  cfg_t        cfg;
  walk_state_t st;
  walk_state_t st_next;
  in_item_t    in_q;
  logic        in_vld_q;
  out_item_t   res_q;
  logic        res_valid;
  logic        adv;
  logic        proc;
  logic        emit;
  out_item_t   res;

  assign cfg_ready = 1'b1;
  assign adv = !res_valid || !out_stall;
  assign proc = in_vld_q && adv;
  assign in_stall = in_vld_q && !adv;
  assign out_valid = res_valid;
  assign out_data = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_mode <= 1'b0;
      cfg.target_type <= '0;
      cfg.region_start <= '0;
      cfg.region_length <= REGION_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCAN_MODE:     cfg.scan_mode <= cfg_data[0];
        REG_TARGET_TYPE:   cfg.target_type <= cfg_data[TYPE_W-1:0];
        REG_REGION_START:  cfg.region_start <= cfg_data[POS_W-1:0];
        REG_REGION_LENGTH: cfg.region_length <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall) begin
      in_vld_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_q <= in_data;
    end
  end

  bhw_step u_step (
    .cur  (st),
    .item (in_q),
    .cfg  (cfg),
    .nxt  (st_next),
    .emit (emit),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= proc && emit;
      if (proc) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      res_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_finished_quiet: assert property (@(posedge clk) disable iff (rst)
    proc && st.walk_finished && !in_q.restart |=> !res_valid)
    else $error("result from a finished walk");

  a_body_outside_header: assert property (@(posedge clk) disable iff (rst)
    st.header_byte_count != 4'd0 |-> st.body_bytes_left == 64'd0)
    else $error("body count live inside a header");

  a_end_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_q.status == ST_REGION_END |->
      res_q.header_length == 5'd0 && res_q.box_type == 32'd0)
    else $error("region end carries header fields");

  a_stop_finishes: assert property (@(posedge clk) disable iff (rst)
    proc && emit && res.status != ST_BOX |=> st.walk_finished)
    else $error("terminal result left the walk running");
`endif

endmodule
